>>> rtl/sitoa_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, sequencer states and control structs.
// No dependencies.
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int N_DIGITS = 10;
    localparam int BCD_W    = N_DIGITS * 4;
    localparam int IDX_W    = $clog2(N_DIGITS);
    localparam int CNT_W    = $clog2(VALUE_W);

    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctl;

    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_emit_req;

    typedef logic [N_DIGITS-1:0][3:0] t_digits;

endpackage

`default_nettype wire

>>> rtl/sitoa_if.sv
// Valid/ready channel interfaces for the integer input and the character output.
// Depends on sitoa_pkg.
`default_nettype none

interface sitoa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sitoa_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
    logic                           valid;
    logic                           ready;
    logic [sitoa_pkg::CHAR_W-1:0]   ascii_char;
    logic                           is_last;

    modport source (output valid, output ascii_char, output is_last, input ready);
    modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface

`default_nettype wire

>>> rtl/sitoa_dabble.sv
// Binary to BCD converter: one shift-and-add-3 step per cycle while step is asserted, over all ten nibbles.
// Depends on sitoa_pkg.
`default_nettype none

module sitoa_dabble (
    input  logic                          i_clk,
    input  sitoa_pkg::t_dab_ctl           i_ctl,
    input  logic [sitoa_pkg::VALUE_W-1:0] i_mag,
    output logic [sitoa_pkg::BCD_W-1:0]   o_bcd
);
    import sitoa_pkg::*;

    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [VALUE_W-1:0] r_bin;
    logic [VALUE_W-1:0] n_bin;
    logic [BCD_W-1:0]   adj;

    always_comb begin
        for (int i = 0; i < N_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = 4'(r_bcd[i*4 +: 4] + 4'd3);
            end else begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_ctl.load) begin
            n_bcd = '0;
            n_bin = i_mag;
        end else if (i_ctl.step) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_bcd = r_bcd;

endmodule

`default_nettype wire

>>> rtl/sitoa_emit.sv
// Output register for the character channel; takes a new word while the old one leaves.
// Depends on sitoa_pkg and sitoa_if.
`default_nettype none

module sitoa_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sitoa_pkg::t_emit_req i_req,
    output logic                 o_can_push,
    sitoa_out_if.source          o_char_ch
);
    import sitoa_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    assign o_can_push = !r_valid || o_char_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_req.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_req.push) begin
            r_char <= i_req.ch;
            r_last <= i_req.last;
        end
    end

    assign o_char_ch.valid      = r_valid;
    assign o_char_ch.ascii_char = r_char;
    assign o_char_ch.is_last    = r_last;

endmodule

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character word per output transfer.
// The first character is registered after the 32-step shift-and-add-3 loop: the minus sign when
// negative, else the most significant digit. A new number is accepted only in idle, after the last
// character of the previous one has been pushed to the output register.
// Synchronous active-low reset clears the sequencer and the output valid; no memory to clear.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitoa_in_if.sink    i_value_ch,
    sitoa_out_if.source o_char_ch
);
    import sitoa_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_neg;
    logic               in_acc;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd;
    t_digits            digits;
    logic [IDX_W-1:0]   msd;
    logic [3:0]         digit;
    logic               can_push;
    t_dab_ctl           dab_ctl;
    t_emit_req          emit_req;

    assign in_acc = i_value_ch.valid && i_value_ch.ready;
    assign raw    = i_value_ch.value;
    assign mag    = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    assign digits = bcd;
    assign digit  = digits[r_idx];

    always_comb begin
        msd = '0;
        for (int i = 0; i < N_DIGITS; i++) begin
            if (digits[i] != 4'd0) begin
                msd = IDX_W'(i);
            end
        end
    end

    sitoa_dabble u_dabble (
        .i_clk (i_clk),
        .i_ctl (dab_ctl),
        .i_mag (mag),
        .o_bcd (bcd)
    );

    sitoa_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (emit_req),
        .o_can_push (can_push),
        .o_char_ch  (o_char_ch)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == CNT_LAST) n_state = ST_SIGN;
            end
            ST_SIGN: begin
                if (!r_neg || can_push) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (can_push && r_idx == '0) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_value_ch.ready = 1'b0;
        dab_ctl.load     = in_acc;
        dab_ctl.step     = 1'b0;
        emit_req.push    = 1'b0;
        emit_req.ch      = CHAR_ZERO;
        emit_req.last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_value_ch.ready = 1'b1;
            end
            ST_CONV: begin
                dab_ctl.step = 1'b1;
            end
            ST_SIGN: begin
                emit_req.push = r_neg;
                emit_req.ch   = CHAR_MINUS;
            end
            ST_DIGIT: begin
                emit_req.push = 1'b1;
                emit_req.ch   = CHAR_W'(CHAR_ZERO + CHAR_W'(digit));
                emit_req.last = (r_idx == '0);
            end
            default: begin
                i_value_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_neg <= raw[VALUE_W-1];
                r_cnt <= '0;
            end else if (r_state == ST_CONV) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end
            if (r_state == ST_SIGN) begin
                r_idx <= msd;
            end else if (r_state == ST_DIGIT && can_push && r_idx != '0) begin
                r_idx <= IDX_W'(r_idx - 1'b1);
            end
        end
    end

    a_acc_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_CONV)
        else $error("accepted number did not start conversion");

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == CNT_LAST) |=> r_state == ST_SIGN)
        else $error("conversion did not end after the last step");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT) |-> (r_idx < IDX_W'(N_DIGITS) && digit <= 4'd9))
        else $error("digit index or BCD digit out of range");

endmodule

`default_nettype wire
